>>> hw/rtl/pvb_pkg.sv
package pvb_pkg;

  localparam int MAX_VOXELS = 65536;
  localparam int MAX_POINTS = 65536;
  localparam int COORD_BITS = 32;

  // Field widths of the channels
  localparam int COORD_W    = 32;
  localparam int PNUM_W     = 16;
  localparam int IDX_OUT_W  = 16;
  localparam int CLR_OUT_W  = 17;
  localparam int CELLS_W    = 17;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 56;

  // Storage widths
  localparam int VOX_W  = $clog2(MAX_VOXELS);
  localparam int CNT_W  = VOX_W + 1;
  localparam int VENT_W = PNUM_W + 1;
  localparam int CW     = (COORD_BITS < 32) ? COORD_BITS : 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z    = 3'd6;

  // One result beat, accepted in the lowest bit
  typedef struct packed {
    logic [CLR_OUT_W-1:0] cleared_count;
    logic                 previous_valid;
    logic [PNUM_W-1:0]    previous_point;
    logic                 newly_occupied;
    logic [IDX_OUT_W-1:0] voxel_index;
    logic                 accepted;
  } res_t;

  // Wrap a coordinate to CW bits and sign extend to 33 bits
  function automatic logic signed [COORD_W:0] coord_ext(input logic [COORD_W-1:0] raw);
    logic [COORD_W:0] r;
    r = {{(COORD_W + 1 - CW){raw[CW-1]}}, raw[CW-1:0]};
    return signed'(r);
  endfunction

endpackage

>>> hw/rtl/point_voxel_binning_core.sv
// Voxel binning of a point stream.
// in_*  : one beat per item. in_tuser = 0 adds the point in in_tdata to the grid,
//         in_tuser = 1 releases every used voxel.
// out_* : one result beat per input beat, in input order.
// cfg_* : register writes, taken at any edge with cfg_we high; write them while idle.
// An add runs one subtract stage, three axis products and two index products through
// the one shared 32x32 multiplier, then one read-modify-write of the voxel memory;
// a point that falls outside the grid finishes after the axis checks.
// A clear walks the used list one entry a cycle through the list memory.
// After reset the block sweeps all MAX_VOXELS (65536) entries of the voxel memory
// clean, one entry a cycle, with in_tready low; config writes are taken meanwhile.
// The result sits in an output register: the next item is accepted and worked on
// while it waits, and only its own result stalls until out_tready takes the last one.
module point_voxel_binning_core
  import pvb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // point_x[31:0], point_y[63:32], point_z[95:64], point_number[111:96]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // accepted[0], voxel_index[16:1], newly_occupied[17], previous_point[33:18],
  // previous_valid[34], cleared_count[51:35], zero fill[55:52]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DIFF  = 4'd2;
  localparam logic [3:0] ST_AXIS  = 4'd3;
  localparam logic [3:0] ST_IDX_A = 4'd4;
  localparam logic [3:0] ST_IDX_B = 4'd5;
  localparam logic [3:0] ST_IDX_C = 4'd6;
  localparam logic [3:0] ST_IDX_D = 4'd7;
  localparam logic [3:0] ST_RMW   = 4'd8;
  localparam logic [3:0] ST_CLR   = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  // Configuration
  logic signed [COORD_W-1:0] gmin_x_r, gmin_y_r, gmin_z_r;
  logic [CFG_W-1:0]          inv_r;
  logic [CELLS_W-1:0]        nx_r, ny_r, nz_r;

  // Control
  logic [3:0]       state_r, state_nxt;
  logic [1:0]       ax_r;
  logic [VOX_W-1:0] init_cnt_r;
  logic [CNT_W-1:0] used_cnt_r;
  logic [CNT_W-1:0] clr_k_r;
  logic             rd_pend_r;
  logic             rej_r;
  logic             out_tvalid_r;

  // Datapath
  logic [COORD_W-1:0] pnt_x_r, pnt_y_r, pnt_z_r;
  logic [PNUM_W-1:0]  pnum_r;
  logic [COORD_W-1:0] mag_r [3];
  logic [2:0]         neg_r;
  logic [63:0]        prod_r;
  logic [CELLS_W-1:0] cell_r [3];
  logic [VOX_W-1:0]   t_r;
  logic [VOX_W-1:0]   flat_r;
  res_t               wres_r, res_r;

  // Memories
  logic [VENT_W-1:0] vmem [MAX_VOXELS];
  logic [VOX_W-1:0]  umem [MAX_VOXELS];
  logic [VENT_W-1:0] vm_q_r;
  logic [VOX_W-1:0]  um_q_r;

  logic              vm_we, vm_re, um_we, um_re;
  logic [VOX_W-1:0]  vm_waddr, vm_raddr, um_waddr, um_raddr;
  logic [VENT_W-1:0] vm_wdata;

  logic                   in_acc;
  logic signed [COORD_W:0] p_ext [3];
  logic signed [COORD_W:0] g_ext [3];
  logic signed [COORD_W:0] diff [3];
  logic [COORD_W-1:0]     mul_a, mul_b;
  logic [1:0]             chk_idx;
  logic                   chk_neg;
  logic [CELLS_W-1:0]     chk_cnt;
  logic                   bad_ax;
  logic [35:0]            t_sum;
  logic [37:0]            f_sum;
  logic                   t_bad, f_bad;
  logic                   occ;
  logic                   pnum_ok;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'(res_r);

  assign pnum_ok = (32'(pnum_r) < MAX_POINTS);
  assign occ     = vm_q_r[VENT_W-1];

  // Per-axis difference to the grid corner, all three at once
  always_comb begin
    p_ext[0] = coord_ext(pnt_x_r);
    p_ext[1] = coord_ext(pnt_y_r);
    p_ext[2] = coord_ext(pnt_z_r);
    g_ext[0] = {gmin_x_r[COORD_W-1], gmin_x_r};
    g_ext[1] = {gmin_y_r[COORD_W-1], gmin_y_r};
    g_ext[2] = {gmin_z_r[COORD_W-1], gmin_z_r};
    for (int i = 0; i < 3; i++) begin
      diff[i] = p_ext[i] - g_ext[i];
    end
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_AXIS: begin
        mul_b = inv_r;
        case (ax_r)
          2'd0:    mul_a = mag_r[0];
          2'd1:    mul_a = mag_r[1];
          2'd2:    mul_a = mag_r[2];
          default: mul_a = '0;
        endcase
      end
      ST_IDX_A: begin
        mul_a = COORD_W'(cell_r[2]);
        mul_b = COORD_W'(ny_r);
      end
      ST_IDX_C: begin
        mul_a = COORD_W'(t_r);
        mul_b = COORD_W'(nx_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Range check of the axis whose product is in prod_r
  always_comb begin
    chk_idx = ax_r - 2'd1;
    case (chk_idx)
      2'd0:    begin chk_neg = neg_r[0]; chk_cnt = nx_r; end
      2'd1:    begin chk_neg = neg_r[1]; chk_cnt = ny_r; end
      2'd2:    begin chk_neg = neg_r[2]; chk_cnt = nz_r; end
      default: begin chk_neg = 1'b0;     chk_cnt = nx_r; end
    endcase
    bad_ax = (chk_neg && (inv_r != '0)) || (prod_r[63:32] >= 32'(chk_cnt));
  end

  // Horner steps of the flat index
  assign t_sum = prod_r[35:0] + 36'(cell_r[1]);
  assign t_bad = (t_sum >= 36'(MAX_VOXELS));
  assign f_sum = prod_r[37:0] + 38'(cell_r[0]);
  assign f_bad = (f_sum >= 38'(MAX_VOXELS));

  // Memory port control
  always_comb begin
    vm_we    = 1'b0;
    vm_waddr = flat_r;
    vm_wdata = {1'b1, pnum_r};
    vm_re    = 1'b0;
    vm_raddr = f_sum[VOX_W-1:0];
    um_we    = 1'b0;
    um_waddr = used_cnt_r[VOX_W-1:0];
    um_re    = 1'b0;
    um_raddr = clr_k_r[VOX_W-1:0];
    case (state_r)
      ST_INIT: begin
        vm_we    = 1'b1;
        vm_waddr = init_cnt_r;
        vm_wdata = '0;
      end
      ST_IDX_D: vm_re = !f_bad;
      ST_RMW: begin
        vm_we = 1'b1;
        um_we = !occ && (used_cnt_r < CNT_W'(MAX_VOXELS));
      end
      ST_CLR: begin
        // release the voxel read from the list in the previous cycle
        vm_we    = rd_pend_r;
        vm_waddr = um_q_r;
        vm_wdata = '0;
        um_re    = (clr_k_r < used_cnt_r);
      end
      default: begin
        vm_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vm_waddr] <= vm_wdata;
    end
    if (vm_re) begin
      vm_q_r <= vmem[vm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (um_we) begin
      umem[um_waddr] <= flat_r;
    end
    if (um_re) begin
      um_q_r <= umem[um_raddr];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:  if (init_cnt_r == VOX_W'(MAX_VOXELS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = in_tuser ? ST_CLR : ST_DIFF;
      ST_DIFF:  state_nxt = ST_AXIS;
      ST_AXIS:  if (ax_r == 2'd3) state_nxt = (rej_r || bad_ax) ? ST_FIN : ST_IDX_A;
      ST_IDX_A: state_nxt = ST_IDX_B;
      ST_IDX_B: state_nxt = t_bad ? ST_FIN : ST_IDX_C;
      ST_IDX_C: state_nxt = ST_IDX_D;
      ST_IDX_D: state_nxt = f_bad ? ST_FIN : ST_RMW;
      ST_RMW:   state_nxt = ST_FIN;
      ST_CLR:   if (!rd_pend_r && (clr_k_r >= used_cnt_r)) state_nxt = ST_FIN;
      ST_FIN:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      init_cnt_r   <= '0;
      used_cnt_r   <= '0;
      clr_k_r      <= '0;
      rd_pend_r    <= 1'b0;
      ax_r         <= '0;
      rej_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      gmin_x_r     <= '0;
      gmin_y_r     <= '0;
      gmin_z_r     <= '0;
      inv_r        <= CFG_W'(65536);
      nx_r         <= CELLS_W'(16);
      ny_r         <= CELLS_W'(16);
      nz_r         <= CELLS_W'(16);
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_MIN_X: gmin_x_r <= signed'(cfg_data);
          CFG_GRID_MIN_Y: gmin_y_r <= signed'(cfg_data);
          CFG_GRID_MIN_Z: gmin_z_r <= signed'(cfg_data);
          CFG_INV_SIZE:   inv_r    <= cfg_data;
          CFG_CELLS_X:    nx_r     <= cfg_data[CELLS_W-1:0];
          CFG_CELLS_Y:    ny_r     <= cfg_data[CELLS_W-1:0];
          CFG_CELLS_Z:    nz_r     <= cfg_data[CELLS_W-1:0];
          default: ;
        endcase
      end

      if (state_r == ST_INIT) begin
        init_cnt_r <= init_cnt_r + 1'b1;
      end

      case (state_r)
        ST_IDLE: begin
          clr_k_r   <= '0;
          rd_pend_r <= 1'b0;
        end
        ST_DIFF: begin
          ax_r  <= '0;
          rej_r <= !pnum_ok;
        end
        ST_AXIS: begin
          ax_r <= ax_r + 2'd1;
          if (ax_r != 2'd0) begin
            rej_r <= rej_r || bad_ax;
          end
        end
        ST_RMW: begin
          if (um_we) begin
            used_cnt_r <= used_cnt_r + 1'b1;
          end
        end
        ST_CLR: begin
          rd_pend_r <= um_re;
          if (um_re) begin
            clr_k_r <= clr_k_r + 1'b1;
          end else if (!rd_pend_r) begin
            used_cnt_r <= '0;
          end
        end
        default: ;
      endcase

      // drop the beat once taken; load the finished result over it
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if ((state_r == ST_FIN) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= {32'b0, mul_a} * {32'b0, mul_b};

    if (in_acc) begin
      pnt_x_r <= in_tdata[31:0];
      pnt_y_r <= in_tdata[63:32];
      pnt_z_r <= in_tdata[95:64];
      pnum_r  <= in_tdata[111:96];
    end

    case (state_r)
      ST_DIFF: begin
        wres_r <= '0;
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= diff[i][COORD_W];
          mag_r[i] <= diff[i][COORD_W] ? COORD_W'(-diff[i]) : diff[i][COORD_W-1:0];
        end
      end
      ST_AXIS: begin
        if (ax_r != 2'd0) begin
          case (chk_idx)
            2'd0:    cell_r[0] <= prod_r[32 +: CELLS_W];
            2'd1:    cell_r[1] <= prod_r[32 +: CELLS_W];
            default: cell_r[2] <= prod_r[32 +: CELLS_W];
          endcase
        end
      end
      ST_IDX_B: t_r    <= t_sum[VOX_W-1:0];
      ST_IDX_D: flat_r <= f_sum[VOX_W-1:0];
      ST_RMW: begin
        wres_r.accepted       <= 1'b1;
        wres_r.voxel_index    <= IDX_OUT_W'(flat_r);
        wres_r.newly_occupied <= !occ;
        wres_r.previous_point <= occ ? vm_q_r[PNUM_W-1:0] : '0;
        wres_r.previous_valid <= occ;
      end
      ST_CLR: begin
        // cleared_count is the top field; every other field stays zero
        wres_r <= res_t'({CLR_OUT_W'(used_cnt_r), {($bits(res_t) - CLR_OUT_W){1'b0}}});
      end
      default: ;
    endcase

    if ((state_r == ST_FIN) && (!out_tvalid_r || out_tready)) begin
      res_r <= wres_r;
    end
  end

endmodule
